### sv/apcs_pkg.sv
// Shared types and constants for the ATA PIO command sequencer.
// Used by apcs_core, apcs_burst and the top level; depends on nothing.
`default_nettype none

package apcs_pkg;

    // Input item kinds, carried on the slave tuser.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_REPLY = 2'd1;
    localparam logic [1:0] MODE_HOST_WORD = 2'd2;

    // Bus operation codes of a result.
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_REG_WR = 3'd1;
    localparam logic [2:0] OP_STATUS_RD = 3'd2;
    localparam logic [2:0] OP_DATA_RD = 3'd3;
    localparam logic [2:0] OP_DATA_WR = 3'd4;

    // Task file register offsets from the channel base.
    localparam logic [2:0] TF_DATA = 3'd0;
    localparam logic [2:0] TF_SECCOUNT = 3'd2;
    localparam logic [2:0] TF_LBA_LO = 3'd3;
    localparam logic [2:0] TF_LBA_MID = 3'd4;
    localparam logic [2:0] TF_LBA_HI = 3'd5;
    localparam logic [2:0] TF_DRVHEAD = 3'd6;
    localparam logic [2:0] TF_CMD_STATUS = 3'd7;

    // Device commands and the fixed drive/head bits.
    localparam logic [7:0] ATA_CMD_READ = 8'h20;
    localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
    localparam logic [7:0] ATA_CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DRVHEAD_BASE = 8'hE0;

    // Status bits.
    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    // Configuration register indexes.
    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_DRIVE_MASK = 1'b1;

    localparam logic [31:0] POLL_LIMIT_RESET = 32'd50000000;
    localparam logic [8:0] WORDS_PER_SECTOR = 9'd256;
    localparam int MAX_RESULTS = 8;
    localparam int LEN_W = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_write;
        logic [1:0]  drive;
        logic [27:0] lba;
        logic [7:0]  num_sectors;
        logic [15:0] data_word;
    } item_t;

    typedef struct packed {
        logic        last;
        logic        failed;
        logic        done_res;
        logic        host_data_valid;
        logic [15:0] host_data;
        logic [15:0] bus_data;
        logic [2:0]  bus_register;
        logic        bus_channel;
        logic [2:0]  bus_op;
    } result_t;

    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] len;
    } burst_ctl_t;

endpackage

`default_nettype wire

### sv/apcs_core.sv
// Sequencer state and result builder: one item per cycle turns into a burst
// while the burst buffer is free. Depends on apcs_pkg.
`default_nettype none

module apcs_core
    import apcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire item_t       item,
    input  wire logic        burst_free,
    input  wire logic [31:0] poll_limit,
    input  wire logic [3:0]  drive_present_mask,
    output logic             item_take,
    output burst_ctl_t       burst_ctl,
    output result_t          burst_list [MAX_RESULTS]
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_BSY,
        PH_SECT_BSY,
        PH_SECT_DRQ,
        PH_RD_DATA,
        PH_WR_DATA,
        PH_FLUSH
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] poll_cnt_reg, poll_cnt_next;
    logic [7:0]  sectors_left_reg, sectors_left_next;
    logic [8:0]  word_idx_reg, word_idx_next;
    logic        cmd_write_reg, cmd_write_next;
    logic [1:0]  cmd_drive_reg, cmd_drive_next;
    logic [27:0] cmd_lba_reg, cmd_lba_next;
    logic [7:0]  cmd_count_reg, cmd_count_next;

    result_t          list [MAX_RESULTS];
    logic [LEN_W-1:0] len;
    logic [SLOT_W-1:0] last_idx;
    logic [31:0]      lim;
    logic             poll_ok;
    logic [7:0]       status;
    logic [7:0]       sl_dec;
    logic [8:0]       wi_inc;
    result_t          poll_res;
    result_t          flush_res;

    function automatic result_t mk_res(input logic [2:0] op, input logic chan,
                                       input logic [2:0] rg, input logic [15:0] data);
        result_t r;
        r = '0;
        r.bus_op = op;
        if (op != OP_NONE)
        begin
            r.bus_channel = chan;
            r.bus_register = rg;
        end
        if (op == OP_REG_WR || op == OP_DATA_WR)
        begin
            r.bus_data = data;
        end
        return r;
    endfunction

    function automatic result_t mk_done(input logic fail);
        result_t r;
        r = '0;
        r.done_res = 1'b1;
        r.failed = fail;
        return r;
    endfunction

    assign item_take = item_valid && burst_free;
    assign lim = (poll_limit == 32'd0) ? 32'd1 : poll_limit;
    assign poll_ok = poll_cnt_reg < lim;
    assign status = item.data_word[7:0];
    assign sl_dec = sectors_left_reg - 8'd1;
    assign wi_inc = word_idx_reg + 9'd1;
    assign poll_res = mk_res(OP_STATUS_RD, cmd_drive_reg[1], TF_CMD_STATUS, 16'h0000);
    assign flush_res = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_CMD_STATUS,
                              {8'h00, ATA_CMD_FLUSH});

    // Next state and the list of results for the item at hand.
    always_comb
    begin
        phase_next = phase_reg;
        poll_cnt_next = poll_cnt_reg;
        sectors_left_next = sectors_left_reg;
        word_idx_next = word_idx_reg;
        cmd_write_next = cmd_write_reg;
        cmd_drive_next = cmd_drive_reg;
        cmd_lba_next = cmd_lba_reg;
        cmd_count_next = cmd_count_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            list[i] = '0;
        end
        len = '0;

        if (item.mode == MODE_START && phase_reg == PH_IDLE)
        begin
            if (!drive_present_mask[item.drive])
            begin
                list[0] = mk_done(1'b1);
                len = LEN_W'(1);
            end
            else
            begin
                cmd_write_next = item.is_write;
                cmd_drive_next = item.drive;
                cmd_lba_next = item.lba;
                cmd_count_next = item.num_sectors;
                sectors_left_next = item.num_sectors;
                word_idx_next = '0;
                list[0] = mk_res(OP_STATUS_RD, item.drive[1], TF_CMD_STATUS, 16'h0000);
                poll_cnt_next = 32'd1;
                phase_next = PH_PRE_BSY;
                len = LEN_W'(1);
            end
        end
        else if (item.mode == MODE_REPLY && phase_reg == PH_PRE_BSY)
        begin
            if (!status[ST_BSY_BIT])
            begin
                // Task file setup, then the first sector wait, the flush or the end.
                list[0] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_DRVHEAD,
                                 {8'h00, DRVHEAD_BASE | {3'b000, cmd_drive_reg[0],
                                                         cmd_lba_reg[27:24]}});
                list[1] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_SECCOUNT,
                                 {8'h00, cmd_count_reg});
                list[2] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_LBA_LO,
                                 {8'h00, cmd_lba_reg[7:0]});
                list[3] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_LBA_MID,
                                 {8'h00, cmd_lba_reg[15:8]});
                list[4] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_LBA_HI,
                                 {8'h00, cmd_lba_reg[23:16]});
                list[5] = mk_res(OP_REG_WR, cmd_drive_reg[1], TF_CMD_STATUS,
                                 {8'h00, cmd_write_reg ? ATA_CMD_WRITE : ATA_CMD_READ});
                if (sectors_left_reg != 8'd0)
                begin
                    list[6] = poll_res;
                    poll_cnt_next = 32'd1;
                    phase_next = PH_SECT_BSY;
                    len = LEN_W'(7);
                end
                else if (cmd_write_reg)
                begin
                    list[6] = flush_res;
                    list[7] = poll_res;
                    poll_cnt_next = 32'd1;
                    phase_next = PH_FLUSH;
                    len = LEN_W'(8);
                end
                else
                begin
                    list[6] = mk_done(1'b0);
                    phase_next = PH_IDLE;
                    len = LEN_W'(7);
                end
            end
            else if (poll_ok)
            begin
                list[0] = poll_res;
                poll_cnt_next = poll_cnt_reg + 32'd1;
                len = LEN_W'(1);
            end
            else
            begin
                list[0] = mk_done(1'b1);
                phase_next = PH_IDLE;
                len = LEN_W'(1);
            end
        end
        else if (item.mode == MODE_REPLY && phase_reg == PH_SECT_BSY)
        begin
            len = LEN_W'(1);
            if (!status[ST_BSY_BIT])
            begin
                list[0] = poll_res;
                poll_cnt_next = 32'd1;
                phase_next = PH_SECT_DRQ;
            end
            else if (poll_ok)
            begin
                list[0] = poll_res;
                poll_cnt_next = poll_cnt_reg + 32'd1;
            end
            else
            begin
                list[0] = mk_done(1'b1);
                phase_next = PH_IDLE;
            end
        end
        else if (item.mode == MODE_REPLY && phase_reg == PH_SECT_DRQ)
        begin
            // Error is checked ahead of DRQ, whatever BSY shows.
            if (status[ST_ERR_BIT])
            begin
                list[0] = mk_done(1'b1);
                phase_next = PH_IDLE;
                len = LEN_W'(1);
            end
            else if (status[ST_DRQ_BIT])
            begin
                word_idx_next = '0;
                if (cmd_write_reg)
                begin
                    phase_next = PH_WR_DATA;
                end
                else
                begin
                    phase_next = PH_RD_DATA;
                    list[0] = mk_res(OP_DATA_RD, cmd_drive_reg[1], TF_DATA, 16'h0000);
                    len = LEN_W'(1);
                end
            end
            else if (poll_ok)
            begin
                list[0] = poll_res;
                poll_cnt_next = poll_cnt_reg + 32'd1;
                len = LEN_W'(1);
            end
            else
            begin
                list[0] = mk_done(1'b1);
                phase_next = PH_IDLE;
                len = LEN_W'(1);
            end
        end
        else if (item.mode == MODE_REPLY && phase_reg == PH_RD_DATA)
        begin
            word_idx_next = wi_inc;
            len = LEN_W'(1);
            if (wi_inc < WORDS_PER_SECTOR)
            begin
                list[0] = mk_res(OP_DATA_RD, cmd_drive_reg[1], TF_DATA, 16'h0000);
            end
            else
            begin
                // End of sector on a read: next sector wait or done.
                word_idx_next = '0;
                sectors_left_next = sl_dec;
                if (sl_dec != 8'd0)
                begin
                    list[0] = poll_res;
                    poll_cnt_next = 32'd1;
                    phase_next = PH_SECT_BSY;
                end
                else
                begin
                    list[0] = mk_done(1'b0);
                    phase_next = PH_IDLE;
                end
            end
            list[0].host_data = item.data_word;
            list[0].host_data_valid = 1'b1;
        end
        else if (item.mode == MODE_HOST_WORD && phase_reg == PH_WR_DATA)
        begin
            list[0] = mk_res(OP_DATA_WR, cmd_drive_reg[1], TF_DATA, item.data_word);
            word_idx_next = wi_inc;
            len = LEN_W'(1);
            if (wi_inc >= WORDS_PER_SECTOR)
            begin
                // End of sector on a write: next sector wait or the flush.
                word_idx_next = '0;
                sectors_left_next = sl_dec;
                poll_cnt_next = 32'd1;
                if (sl_dec != 8'd0)
                begin
                    list[1] = poll_res;
                    phase_next = PH_SECT_BSY;
                    len = LEN_W'(2);
                end
                else
                begin
                    list[1] = flush_res;
                    list[2] = poll_res;
                    phase_next = PH_FLUSH;
                    len = LEN_W'(3);
                end
            end
        end
        else if (item.mode == MODE_REPLY && phase_reg == PH_FLUSH)
        begin
            len = LEN_W'(1);
            if (status[ST_BSY_BIT] && poll_ok)
            begin
                list[0] = poll_res;
                poll_cnt_next = poll_cnt_reg + 32'd1;
            end
            else
            begin
                list[0] = mk_done(1'b0);
                phase_next = PH_IDLE;
            end
        end

        last_idx = SLOT_W'(len - LEN_W'(1));
        if (len != '0)
        begin
            list[last_idx].last = 1'b1;
        end
    end

    assign burst_ctl.load = item_take && (len != '0);
    assign burst_ctl.len = len;
    assign burst_list = list;

    // Sequencer state, updated once for each item taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            poll_cnt_reg <= '0;
            sectors_left_reg <= '0;
            word_idx_reg <= '0;
            cmd_write_reg <= 1'b0;
            cmd_drive_reg <= '0;
            cmd_lba_reg <= '0;
            cmd_count_reg <= '0;
        end
        else if (item_take)
        begin
            phase_reg <= phase_next;
            poll_cnt_reg <= poll_cnt_next;
            sectors_left_reg <= sectors_left_next;
            word_idx_reg <= word_idx_next;
            cmd_write_reg <= cmd_write_next;
            cmd_drive_reg <= cmd_drive_next;
            cmd_lba_reg <= cmd_lba_next;
            cmd_count_reg <= cmd_count_next;
        end
    end

endmodule

`default_nettype wire

### sv/apcs_burst.sv
// Result burst buffer: holds up to eight results and shifts one beat out per take.
// Depends on apcs_pkg.
`default_nettype none

module apcs_burst
    import apcs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire burst_ctl_t burst_ctl,
    input  wire result_t burst_list [MAX_RESULTS],
    output logic         burst_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    result_t          slot_reg [MAX_RESULTS];
    logic [LEN_W-1:0] len_reg;
    logic             take;

    assign out_valid = (len_reg != '0);
    assign take = out_valid && out_ready;
    assign burst_free = (len_reg == '0) || (len_reg == LEN_W'(1) && out_ready);
    assign out_res = slot_reg[0];

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (burst_ctl.load)
        begin
            len_reg <= burst_ctl.len;
        end
        else if (take)
        begin
            len_reg <= len_reg - LEN_W'(1);
        end
    end

    // Result slots: load a whole burst, or shift toward slot zero on each beat.
    always_ff @(posedge clk)
    begin
        if (burst_ctl.load)
        begin
            slot_reg <= burst_list;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

### sv/ata_pio_command_sequencer_top.sv
// Top level of the ATA PIO LBA28 command sequencer: input register, config registers.
// Depends on apcs_pkg, apcs_core and apcs_burst.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tuser mode, s_tdata command or word
//  m_*      out        m_tvalid/m_tready  m_tdata result, m_tlast end of burst
//  cfg_*    in         cfg_we             cfg_index, cfg_data
//
// An item is registered at the input and handled once the burst buffer is free,
// which loads all of its results (zero to eight) into the burst buffer; the beats
// are offered from the registered slots of that buffer. The output gives one beat
// per cycle while m_tready is high. A new item is handled in the cycle the last
// beat of the previous burst is taken. Reset clears the sequencer to idle,
// poll_limit to 50000000 and the drive mask to zero.
`default_nettype none

module ata_pio_command_sequencer_top
    import apcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: is_write[0], drive[2:1], lba[30:3], num_sectors[38:31],
    //          data_word[54:39], zero[55]
    input  wire logic [55:0] s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: bus_op[2:0], bus_channel[3], bus_register[6:4], bus_data[22:7],
    //          host_data[38:23], host_data_valid[39], done_res[40], failed[41],
    //          zero[47:42]
    output logic [47:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic        in_valid_reg;
    item_t       item_reg;
    logic [31:0] poll_limit_reg;
    logic [3:0]  drive_mask_reg;
    logic        item_take;
    logic        burst_free;
    burst_ctl_t  burst_ctl;
    result_t     burst_list [MAX_RESULTS];
    result_t     out_res;

    assign s_tready = !in_valid_reg || item_take;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.mode <= s_tuser;
            item_reg.is_write <= s_tdata[0];
            item_reg.drive <= s_tdata[2:1];
            item_reg.lba <= s_tdata[30:3];
            item_reg.num_sectors <= s_tdata[38:31];
            item_reg.data_word <= s_tdata[54:39];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_LIMIT_RESET;
            drive_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                CFG_DRIVE_MASK: drive_mask_reg <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    apcs_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (in_valid_reg),
        .item               (item_reg),
        .burst_free         (burst_free),
        .poll_limit         (poll_limit_reg),
        .drive_present_mask (drive_mask_reg),
        .item_take          (item_take),
        .burst_ctl          (burst_ctl),
        .burst_list         (burst_list)
    );

    apcs_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst_ctl  (burst_ctl),
        .burst_list (burst_list),
        .burst_free (burst_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    // Output beat packing.
    assign m_tdata = {6'b000000, out_res.failed, out_res.done_res,
                      out_res.host_data_valid, out_res.host_data, out_res.bus_data,
                      out_res.bus_register, out_res.bus_channel, out_res.bus_op};
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the ATA PIO LBA28 command sequencer top level.
// It acts as both the host and the device and predicts every result beat from its own model.
// Depends on apcs_pkg and ata_pio_command_sequencer_top.
`timescale 1ns / 1ps

module tb_top;
    import apcs_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int END_WAIT_CYCLES = 20000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_CAP = 20;
    localparam int RANDOM_ITEMS = 15;
    localparam int TAIL_WORDS = 24;

    // The input kind that no phase of the sequencer acts on.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Command phases tracked by the predictor.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE_BSY,
        PH_SECT_BSY,
        PH_SECT_DRQ,
        PH_RD_DATA,
        PH_WR_DATA,
        PH_FLUSH
    } seq_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata: is_write[0], drive[2:1], lba[30:3], num_sectors[38:31],
    //          data_word[54:39], zero[55]
    logic [55:0] s_tdata;
    // s_tuser: mode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata: bus_op[2:0], bus_channel[3], bus_register[6:4], bus_data[22:7],
    //          host_data[38:23], host_data_valid[39], done_res[40], failed[41],
    //          zero[47:42]
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Predictor state and its copy of the configuration registers.
    seq_phase_t  seq_phase = PH_IDLE;
    logic [31:0] polls_done = '0;
    logic [7:0]  sectors_left = '0;
    logic [8:0]  word_idx = '0;
    logic        cmd_wr = 1'b0;
    logic [1:0]  cmd_drive = '0;
    logic [27:0] cmd_lba = '0;
    logic [7:0]  cmd_count = '0;
    logic [31:0] poll_limit_reg = POLL_LIMIT_RESET;
    logic [3:0]  present_mask = '0;

    // Beats caused by the item being predicted, and all beats still owed by the block.
    result_t burst[$];
    result_t beats_due[$];

    // Device behavior knobs and idling, in percent.
    int busy_pct = 30;
    int err_pct = 10;
    int drq_pct = 10;
    int noise_pct = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    int err_cnt = 0;
    int item_cnt = 0;
    int beat_cnt = 0;
    int done_cnt = 0;
    int cmd_fail_cnt = 0;
    int data_word_cnt = 0;
    int cycle_cnt = 0;

    ata_pio_command_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // The receiver stalls at random, one decision per cycle.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Appends one bus operation; unused fields stay zero.
    function automatic void emit_bus(input logic [2:0] op, input logic [2:0] tf_reg,
                                     input logic [15:0] data);
        result_t b;
        b = '0;
        b.bus_op = op;
        if (op != OP_NONE)
        begin
            b.bus_channel = cmd_drive[1];
            b.bus_register = tf_reg;
        end
        if (op == OP_REG_WR || op == OP_DATA_WR)
            b.bus_data = data;
        burst.push_back(b);
    endfunction

    function automatic void emit_done(input logic fail);
        result_t b;
        b = '0;
        b.done_res = 1'b1;
        b.failed = fail;
        burst.push_back(b);
        seq_phase = PH_IDLE;
    endfunction

    // First status read of a new wait.
    function automatic void emit_poll(input seq_phase_t next);
        emit_bus(OP_STATUS_RD, TF_CMD_STATUS, '0);
        polls_done = 32'd1;
        seq_phase = next;
    endfunction

    // Another status read, or the end of the command once the poll budget is spent.
    function automatic void emit_repoll(input logic fail);
        logic [31:0] budget;
        budget = (poll_limit_reg == '0) ? 32'd1 : poll_limit_reg;
        if (polls_done >= budget)
            emit_done(fail);
        else
        begin
            polls_done = polls_done + 32'd1;
            emit_bus(OP_STATUS_RD, TF_CMD_STATUS, '0);
        end
    endfunction

    // Next sector, cache flush after a write, or done after a read.
    function automatic void emit_next_sector();
        if (sectors_left != '0)
            emit_poll(PH_SECT_BSY);
        else if (cmd_wr)
        begin
            emit_bus(OP_REG_WR, TF_CMD_STATUS, {8'h00, ATA_CMD_FLUSH});
            emit_poll(PH_FLUSH);
        end
        else
            emit_done(1'b0);
    endfunction

    function automatic void emit_sector_end();
        word_idx = '0;
        sectors_left = sectors_left - 8'd1;
        emit_next_sector();
    endfunction

    // Works out the beats that one accepted item causes and queues them.
    function automatic void advance_sequencer(input item_t it);
        logic [7:0] st;
        result_t b;
        st = it.data_word[7:0];
        burst.delete();
        if (it.mode == MODE_START)
        begin
            if (seq_phase == PH_IDLE)
            begin
                if (!present_mask[it.drive])
                    emit_done(1'b1);
                else
                begin
                    cmd_wr = it.is_write;
                    cmd_drive = it.drive;
                    cmd_lba = it.lba;
                    cmd_count = it.num_sectors;
                    sectors_left = it.num_sectors;
                    word_idx = '0;
                    emit_poll(PH_PRE_BSY);
                end
            end
        end
        else if (it.mode == MODE_HOST_WORD)
        begin
            if (seq_phase == PH_WR_DATA)
            begin
                emit_bus(OP_DATA_WR, TF_DATA, it.data_word);
                word_idx = word_idx + 9'd1;
                if (word_idx >= WORDS_PER_SECTOR)
                    emit_sector_end();
            end
        end
        else if (it.mode == MODE_REPLY)
        begin
            case (seq_phase)
                PH_PRE_BSY:
                    if (st[ST_BSY_BIT])
                        emit_repoll(1'b1);
                    else
                    begin
                        // Task file setup, then the command byte.
                        emit_bus(OP_REG_WR, TF_DRVHEAD,
                                 {8'h00, DRVHEAD_BASE | {3'b000, cmd_drive[0],
                                                         cmd_lba[27:24]}});
                        emit_bus(OP_REG_WR, TF_SECCOUNT, {8'h00, cmd_count});
                        emit_bus(OP_REG_WR, TF_LBA_LO, {8'h00, cmd_lba[7:0]});
                        emit_bus(OP_REG_WR, TF_LBA_MID, {8'h00, cmd_lba[15:8]});
                        emit_bus(OP_REG_WR, TF_LBA_HI, {8'h00, cmd_lba[23:16]});
                        emit_bus(OP_REG_WR, TF_CMD_STATUS,
                                 {8'h00, cmd_wr ? ATA_CMD_WRITE : ATA_CMD_READ});
                        emit_next_sector();
                    end
                PH_SECT_BSY:
                    if (st[ST_BSY_BIT])
                        emit_repoll(1'b1);
                    else
                        emit_poll(PH_SECT_DRQ);
                PH_SECT_DRQ:
                    // ERR wins over DRQ, whatever BSY shows.
                    if (st[ST_ERR_BIT])
                        emit_done(1'b1);
                    else if (st[ST_DRQ_BIT])
                    begin
                        word_idx = '0;
                        if (cmd_wr)
                            seq_phase = PH_WR_DATA;
                        else
                        begin
                            seq_phase = PH_RD_DATA;
                            emit_bus(OP_DATA_RD, TF_DATA, '0);
                        end
                    end
                    else
                        emit_repoll(1'b1);
                PH_RD_DATA:
                begin
                    word_idx = word_idx + 9'd1;
                    if (word_idx < WORDS_PER_SECTOR)
                        emit_bus(OP_DATA_RD, TF_DATA, '0);
                    else
                        emit_sector_end();
                    b = burst[0];
                    b.host_data = it.data_word;
                    b.host_data_valid = 1'b1;
                    burst[0] = b;
                end
                PH_FLUSH:
                    // A flush timeout still ends without failure.
                    if (st[ST_BSY_BIT])
                        emit_repoll(1'b0);
                    else
                        emit_done(1'b0);
                default:
                    ;
            endcase
        end
        if (burst.size() > 0)
        begin
            b = burst[burst.size() - 1];
            b.last = 1'b1;
            burst[burst.size() - 1] = b;
        end
        foreach (burst[i])
            beats_due.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] MISMATCH at beat %0d: %s", $time, beat_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Each beat taken is compared with the oldest expected beat.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            beat_cnt++;
            if (beats_due.size() == 0)
                report_mismatch($sformatf("unexpected beat, m_tdata 0x%0h", m_tdata));
            else
            begin
                want = beats_due.pop_front();
                check_field("bus_op", 16'(m_tdata[2:0]), 16'(want.bus_op));
                check_field("bus_channel", 16'(m_tdata[3]), 16'(want.bus_channel));
                check_field("bus_register", 16'(m_tdata[6:4]), 16'(want.bus_register));
                check_field("bus_data", m_tdata[22:7], want.bus_data);
                check_field("host_data", m_tdata[38:23], want.host_data);
                check_field("host_data_valid", 16'(m_tdata[39]),
                            16'(want.host_data_valid));
                check_field("done_res", 16'(m_tdata[40]), 16'(want.done_res));
                check_field("failed", 16'(m_tdata[41]), 16'(want.failed));
                check_field("last", 16'(m_tlast), 16'(want.last));
                if (want.done_res)
                    done_cnt++;
                if (want.failed)
                    cmd_fail_cnt++;
                if (want.host_data_valid || want.bus_op == OP_DATA_WR)
                    data_word_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Every field random, so that the fields an item does not use still toggle.
    function automatic item_t rand_item(input logic [1:0] mode);
        item_t it;
        it.mode = mode;
        it.is_write = 1'($urandom_range(1));
        it.drive = 2'($urandom_range(3));
        it.lba = 28'($urandom);
        it.num_sectors = 8'($urandom_range(255));
        it.data_word = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic item_t start_cmd(input logic wr, input logic [1:0] drv,
                                        input logic [27:0] lba, input logic [7:0] cnt);
        item_t it;
        it = rand_item(MODE_START);
        it.is_write = wr;
        it.drive = drv;
        it.lba = lba;
        it.num_sectors = cnt;
        return it;
    endfunction

    function automatic item_t status_reply(input logic [7:0] st);
        item_t it;
        it = rand_item(MODE_REPLY);
        it.data_word[7:0] = st;
        return it;
    endfunction

    // The device side: picks a fitting item for the phase the sequencer is in.
    function automatic item_t next_item();
        item_t it;
        logic [7:0] st;
        int r;
        it = rand_item(MODE_REPLY);
        st = 8'($urandom_range(255));
        r = $urandom_range(99);
        if ($urandom_range(99) < noise_pct)
        begin
            it.mode = 2'($urandom_range(3));
            return it;
        end
        case (seq_phase)
            PH_IDLE:
            begin
                it.mode = MODE_START;
                case ($urandom_range(3))
                    0: it.num_sectors = 8'd0;
                    1: it.num_sectors = 8'd1;
                    2: it.num_sectors = 8'd255;
                    default: ;
                endcase
                return it;
            end
            PH_PRE_BSY, PH_SECT_BSY, PH_FLUSH:
                st[ST_BSY_BIT] = (r < busy_pct);
            PH_SECT_DRQ:
                if (r < err_pct)
                    st[ST_ERR_BIT] = 1'b1;
                else
                begin
                    st[ST_ERR_BIT] = 1'b0;
                    st[ST_DRQ_BIT] = (r < err_pct + drq_pct);
                end
            PH_WR_DATA:
                it.mode = MODE_HOST_WORD;
            default:
                ;
        endcase
        it.data_word[7:0] = st;
        return it;
    endfunction

    // Offers one beat, after a random gap, and predicts it once it is taken.
    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {1'b0, it.data_word, it.num_sectors, it.lba, it.drive, it.is_write};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        item_cnt++;
        advance_sequencer(it);
    endtask

    // Holds the sender off until every expected beat has come, then lets
    // ignored items drain out of the block.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (beats_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_POLL_LIMIT)
            poll_limit_reg = value;
        else
            present_mask = value[3:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    // One command that moves full_sectors sectors and then ends on ERR if more remain.
    task automatic run_command(input logic wr, input logic [7:0] cnt, input int full_sectors);
        logic [7:0] moved;
        busy_pct = 25;
        drq_pct = 100;
        noise_pct = 2;
        send_item(start_cmd(wr, 2'($urandom_range(3)), 28'($urandom), cnt));
        while (seq_phase != PH_IDLE)
        begin
            moved = cmd_count - sectors_left;
            err_pct = (moved >= full_sectors) ? 100 : 0;
            send_item(next_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Absent drive, ignored items, the BSY and flush timeouts and the zero sector count.
    task automatic test_directed();
        set_idling(0, 0);
        write_register(CFG_DRIVE_MASK, 32'd0);
        send_item(start_cmd(1'b0, 2'd0, 28'h1234567, 8'd4));
        send_item(rand_item(MODE_REPLY));
        send_item(rand_item(MODE_HOST_WORD));
        send_item(rand_item(MODE_UNUSED));
        drain();
        write_register(CFG_POLL_LIMIT, 32'd2);
        write_register(CFG_DRIVE_MASK, 32'd15);

        // Busy before setup until timeout; a second start meanwhile is ignored.
        send_item(start_cmd(1'b0, 2'd1, 28'h5A5A5A5, 8'd255));
        send_item(start_cmd(1'b1, 2'd2, 28'h0000001, 8'd1));
        send_item(status_reply(8'h80));
        send_item(status_reply(8'h80));

        // Read of zero sectors at the top address on the secondary slave.
        send_item(start_cmd(1'b0, 2'd3, 28'hFFFFFFF, 8'd0));
        send_item(status_reply(8'h7F));

        // Write of zero sectors: straight to the flush, whose timeout is not a failure.
        send_item(start_cmd(1'b1, 2'd0, 28'h0000000, 8'd0));
        send_item(status_reply(8'h80));
        send_item(status_reply(8'h00));
        send_item(status_reply(8'hFF));
        send_item(status_reply(8'h80));

        // Busy at the sector wait until timeout.
        send_item(start_cmd(1'b1, 2'd2, 28'hA5A5A5A, 8'd3));
        send_item(status_reply(8'h00));
        send_item(status_reply(8'h80));
        send_item(status_reply(8'h80));

        // No DRQ once, then ERR while BSY and DRQ are both set.
        send_item(start_cmd(1'b0, 2'd2, 28'h0F0F0F0, 8'd1));
        send_item(status_reply(8'h00));
        send_item(status_reply(8'h00));
        send_item(status_reply(8'hF6));
        send_item(status_reply(8'h89));
        drain();
    endtask

    // One whole sector written under the largest poll limit, ending with the flush.
    task automatic test_full_sectors();
        write_register(CFG_POLL_LIMIT, 32'hFFFF_FFFF);
        set_idling(0, 69);
        run_command(1'b1, 8'd1, 1);
        drain();
    endtask

    // Mostly well-formed commands with random status, plus noise, in four idling mixes.
    // Only noise items can carry DRQ here, so commands mostly end at a wait.
    task automatic test_random();
        logic [31:0] limits [4] = '{32'd1, 32'd0, 32'd3, 32'd6};
        logic [31:0] masks [4] = '{32'd7, 32'd15, 32'd10, 32'd13};
        int send_mix [4] = '{0, 69, 0, 36};
        int stall_mix [4] = '{0, 0, 69, 36};
        int p;
        int n;
        for (p = 0; p < 4; p++)
        begin
            drain();
            write_register(CFG_POLL_LIMIT, limits[p]);
            write_register(CFG_DRIVE_MASK, masks[p]);
            set_idling(send_mix[p], stall_mix[p]);
            busy_pct = 35;
            err_pct = 10;
            drq_pct = 0;
            noise_pct = 5;
            n = 0;
            while (n < RANDOM_ITEMS || seq_phase != PH_IDLE)
            begin
                if (seq_phase == PH_IDLE && $urandom_range(99) < 8)
                    drain();
                send_item(next_item());
                n++;
            end
        end
    endtask

    // A read that reaches the data phase and takes a run of words; the sector is
    // left open since nothing follows it.
    task automatic test_read_words();
        int k;
        drain();
        write_register(CFG_POLL_LIMIT, 32'hFFFF_FFFF);
        write_register(CFG_DRIVE_MASK, 32'd15);
        set_idling(36, 36);
        busy_pct = 25;
        err_pct = 0;
        drq_pct = 100;
        noise_pct = 2;
        send_item(start_cmd(1'b0, 2'($urandom_range(3)), 28'($urandom), 8'd2));
        while (seq_phase != PH_RD_DATA)
            send_item(next_item());
        for (k = 0; k < TAIL_WORDS; k++)
            send_item(next_item());
    endtask

    // Ends the run as failed if the tests have not finished within the cycle limit.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Run timed out after %0d cycles with %0d beats outstanding.",
                 CYCLE_LIMIT, beats_due.size());
        $display("** ata_pio_command_sequencer_top: FAILED **");
        $finish;
    end

    initial
    begin
        int w;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_sectors();
        test_random();
        test_read_words();

        // Let the last beats arrive, then watch for anything extra.
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (w = 0; w < END_WAIT_CYCLES && beats_due.size() > 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (beats_due.size() > 0)
            report_mismatch($sformatf("%0d expected beats never came", beats_due.size()));

        $display("Sent %0d items and checked %0d beats: %0d commands finished,",
                 item_cnt, beat_cnt, done_cnt);
        $display("%0d failed, %0d data words; poll limits from zero to all ones.",
                 cmd_fail_cnt, data_word_cnt);
        if (err_cnt == 0)
            $display("** ata_pio_command_sequencer_top: PASSED **");
        else
            $display("** ata_pio_command_sequencer_top: FAILED **");
        $finish;
    end

endmodule
